// File: rtl/iowp_pkg.sv
// Shared types and constants of the I/O port memory watchpoint unit.
package iowp_pkg;

    localparam int WATCH_SLOTS = 16;
    localparam int SLOT_W      = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] ACT_PORT_RD = 2'd0;
    localparam logic [1:0] ACT_PORT_WR = 2'd1;
    localparam logic [1:0] ACT_MEM     = 2'd2;

    localparam logic [31:0] PORT_CMD    = 32'h0000_8A00;
    localparam logic [31:0] PORT_DATA   = 32'h0000_8A01;
    localparam logic [3:0]  PORT_LEN    = 4'd2;
    localparam logic [31:0] CMD_ENABLE  = 32'h0000_8A00;
    localparam logic [31:0] CMD_SEL0    = 32'h0000_8A01;
    localparam logic [31:0] CMD_SEL1    = 32'h0000_8A02;
    localparam logic [31:0] CMD_ADD     = 32'h0000_8A80;
    localparam logic [31:0] CMD_DISABLE = 32'h0000_8AFF;
    localparam logic [15:0] READ_ID     = 16'h8A00;
    localparam logic [15:0] LOW_MASK    = 16'hFFFF;

    typedef struct packed {
        logic [31:0] data;
        logic [3:0]  size;
        logic [31:0] addr;
        logic [1:0]  action;
    } t_item;

    typedef struct packed {
        logic [3:0]  area_index;
        logic        hit;
        logic [15:0] read_data;
    } t_res;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/io_port_memory_watchpoint_unit.sv
// Top level of the I/O port memory watchpoint unit.
// Port accesses pass through the execute and finish states to the result register; memory
// accesses and range stores also scan up to WATCH_SLOTS watch slots (16 by default).
// One item at a time: the next input transfer is taken only after the result of the last
// one is registered, and a stall on the result side holds it off.
// Synchronous active-low reset disables the unit, clears the holding registers and
// marks every watch slot free at once; no clearing pass is needed.
module io_port_memory_watchpoint_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: action[1:0], addr[31:0], size[3:0], data[31:0], zero pad.
    input  logic [iowp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: read_data[15:0], hit, area_index[3:0], zero pad.
    output logic [iowp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    iowp_pkg::t_item w_item;
    iowp_pkg::t_res  w_res;
    iowp_pkg::t_cmd  w_cmd;
    iowp_pkg::t_sts  w_sts;
    logic [iowp_pkg::IN_TDATA_W-$bits(iowp_pkg::t_item)-1:0] w_unused_pad;

    assign w_item       = iowp_pkg::t_item'(s_axis_tdata[$bits(iowp_pkg::t_item)-1:0]);
    assign w_unused_pad = s_axis_tdata[iowp_pkg::IN_TDATA_W-1:$bits(iowp_pkg::t_item)];

    iowp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    iowp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {(iowp_pkg::OUT_TDATA_W-$bits(iowp_pkg::t_res))'(w_unused_pad & '0),
                           w_res};

endmodule

// File: rtl/iowp_ctrl.sv
// Controller state machine that sequences decode, slot scan and result hand-off.
module iowp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  iowp_pkg::t_sts  i_sts,
    output iowp_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_sts.need_scan ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_cmd.scan = (r_state == ST_SCAN);
    assign o_cmd.emit = (r_state == ST_FINISH) && i_sts.out_free;

endmodule

// File: rtl/iowp_dp.sv
// Datapath with holding registers, watch slots, slot scan and result register.
module iowp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iowp_pkg::t_item i_item,
    input  iowp_pkg::t_cmd  i_cmd,
    output iowp_pkg::t_sts  o_sts,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output iowp_pkg::t_res  o_res
);

    iowp_pkg::t_item r_item;
    logic [31:0]     r_last;
    logic [31:0]     r_pair_lo;
    logic [31:0]     r_pair_hi;
    logic            r_enabled;
    logic            n_enabled;
    logic            r_sel;
    logic            n_sel;
    logic [31:0]     r_hold0;
    logic [31:0]     n_hold0;
    logic [31:0]     r_hold1;
    logic [31:0]     n_hold1;
    logic [iowp_pkg::WATCH_SLOTS-1:0] r_used;
    logic [31:0]     r_start [iowp_pkg::WATCH_SLOTS];
    logic [31:0]     r_end   [iowp_pkg::WATCH_SLOTS];
    logic [iowp_pkg::SLOT_W-1:0] r_idx;
    logic [15:0]     r_rd;
    logic            r_hit;
    logic [3:0]      r_area;
    logic            r_ovalid;
    iowp_pkg::t_res  r_out;

    logic w_cmd_port;
    logic w_dat_port;
    logic w_is_add;
    logic w_is_mem;
    logic w_mem_match;
    logic w_found;
    logic w_last_slot;
    logic [31:0] w_start;
    logic [31:0] w_end;

    assign w_cmd_port = (r_item.action == iowp_pkg::ACT_PORT_WR)
                     && (r_item.addr == iowp_pkg::PORT_CMD)
                     && (r_item.size == iowp_pkg::PORT_LEN);
    assign w_dat_port = (r_item.action == iowp_pkg::ACT_PORT_WR)
                     && (r_item.addr == iowp_pkg::PORT_DATA)
                     && (r_item.size == iowp_pkg::PORT_LEN);
    assign w_is_add   = w_cmd_port && r_enabled && (r_item.data == iowp_pkg::CMD_ADD);
    assign w_is_mem   = (r_item.action == iowp_pkg::ACT_MEM) && r_enabled;

    assign w_start     = r_start[r_idx];
    assign w_end       = r_end[r_idx];
    assign w_mem_match = r_used[r_idx] && (r_last >= w_start) && (r_item.addr < w_end);
    assign w_found     = w_is_mem ? w_mem_match : !r_used[r_idx];
    assign w_last_slot = (r_idx == iowp_pkg::SLOT_W'(iowp_pkg::WATCH_SLOTS - 1));

    assign o_sts.need_scan = w_is_mem || w_is_add;
    assign o_sts.scan_done = w_found || w_last_slot;
    assign o_sts.out_free  = !r_ovalid || i_res_ready;

    always_comb begin
        n_enabled = r_enabled;
        n_sel     = r_sel;
        n_hold0   = r_hold0;
        n_hold1   = r_hold1;
        if (w_dat_port) begin
            if (r_sel) begin
                n_hold1 = {r_hold1[15:0], r_item.data[15:0] & iowp_pkg::LOW_MASK};
            end else begin
                n_hold0 = {r_hold0[15:0], r_item.data[15:0] & iowp_pkg::LOW_MASK};
            end
        end
        if (w_cmd_port) begin
            if (!r_enabled) begin
                if (r_item.data == iowp_pkg::CMD_ENABLE) begin
                    n_enabled = 1'b1;
                    n_hold0   = '0;
                    n_hold1   = '0;
                end
            end else begin
                case (r_item.data)
                    iowp_pkg::CMD_SEL0: begin
                        n_sel = 1'b0;
                    end
                    iowp_pkg::CMD_SEL1: begin
                        n_sel = 1'b1;
                    end
                    iowp_pkg::CMD_ADD: begin
                        n_sel   = 1'b0;
                        n_hold0 = '0;
                        n_hold1 = '0;
                    end
                    iowp_pkg::CMD_DISABLE: begin
                        n_enabled = 1'b0;
                    end
                    default: begin
                        n_sel = r_sel;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_sel     <= 1'b0;
            r_hold0   <= '0;
            r_hold1   <= '0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_enabled <= n_enabled;
                r_sel     <= n_sel;
                r_hold0   <= n_hold0;
                r_hold1   <= n_hold1;
            end
            if (i_cmd.scan && !w_is_mem && !r_used[r_idx]) begin
                r_used[r_idx] <= (r_pair_lo != '0) || (r_pair_hi != '0);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_last    <= r_item.addr + 32'(r_item.size) - 32'd1;
            r_pair_lo <= r_hold0;
            r_pair_hi <= r_hold1;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_area    <= '0;
            r_rd      <= ((r_item.action == iowp_pkg::ACT_PORT_RD) && r_enabled)
                         ? iowp_pkg::READ_ID : 16'd0;
        end
        if (i_cmd.scan) begin
            if (w_is_mem && w_mem_match) begin
                r_hit  <= 1'b1;
                r_area <= 4'(r_idx);
            end
            if (!w_is_mem && !r_used[r_idx]) begin
                r_start[r_idx] <= r_pair_lo;
                r_end[r_idx]   <= r_pair_hi;
            end
            if (!w_found && !w_last_slot) begin
                r_idx <= r_idx + iowp_pkg::SLOT_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_out.read_data  <= r_rd;
            r_out.hit        <= r_hit;
            r_out.area_index <= r_area;
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

endmodule

// File: rtl/iowp_chk.sv
// Port-level checker for the I/O port memory watchpoint unit and its bind.
module iowp_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [iowp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed or dropped while stalled.");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken again before the current item finished.");

    a_no_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[20:17] == 4'd0)
        else $error("Slot index reported without a hit.");

    a_read_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] == 16'd0)
                       || (m_axis_tdata[15:0] == iowp_pkg::READ_ID && !m_axis_tdata[16]))
        else $error("Unexpected read data or read data together with a hit.");

endmodule

bind io_port_memory_watchpoint_unit iowp_chk u_iowp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
